>>> design/pal_pkg.sv
`timescale 1ns / 1ps

package pal_pkg;

    // list geometry
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W    = $clog2(CAPACITY + 1);

    // fixed field widths of the channels
    localparam int ACT_W  = 3;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int STS_W  = 2;

    // width used for position against length compares
    localparam int WIDE_W = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

    // action codes
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_GET    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_LOCATE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd5;

    // status codes
    localparam logic [STS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STS_W-1:0] ST_FULL  = 2'd3;

endpackage

>>> design/pal_if.sv
`timescale 1ns / 1ps

// request channel
interface pal_req_if
    import pal_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output position, output value,
                    input ready);
    modport sink   (input valid, input action, input position, input value,
                    output ready);
endinterface

// response channel
interface pal_rsp_if
    import pal_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STS_W-1:0]         status;
    logic signed [DATA_W-1:0] element;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         count;

    modport source (output valid, output status, output element,
                    output found_position, output count, input ready);
    modport sink   (input valid, input status, input element,
                    input found_position, input count, output ready);
endinterface

>>> design/positional_array_list_core.sv
`timescale 1ns / 1ps

// Positional array list: an ordered list of up to CAPACITY signed 32-bit values
// held in one synchronous memory (one read and one write port, registered
// read), plus a length register.
// Channels: req carries action, position and value; rsp returns status,
// element, found_position and count, one response transaction per request.
// Both use valid/ready; a transaction moves when valid and ready are high.
// One request is worked on at a time; req.ready is high only while idle.
// Clear, rejected requests and undefined actions go straight to the done state;
// get reads one entry; insert and delete move the entries from the position
// to the tail, one entry moved per cycle through the memory port; locate and
// append compare one entry per cycle, starting at the head.
// The response sits in an output register; a new request may be accepted
// while it waits, but the next response is held back until rsp.ready frees it.
// Reset empties the list at once; memory contents are not cleared.

module positional_array_list_core
    import pal_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pal_req_if.sink   req,
    pal_rsp_if.source rsp
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_SHUP  = 11'b000_0000_0010,
        S_SHUPL = 11'b000_0000_0100,
        S_INSW  = 11'b000_0000_1000,
        S_SHDN  = 11'b000_0001_0000,
        S_SHDNL = 11'b000_0010_0000,
        S_GETR  = 11'b000_0100_0000,
        S_GETW  = 11'b000_1000_0000,
        S_SCAN  = 11'b001_0000_0000,
        S_SCANL = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    state_t                   state_reg, state_next;
    logic [LEN_W-1:0]         used_reg, used_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic [ADDR_W-1:0]        pidx_reg, pidx_next;
    logic                     pend_reg, pend_next;
    logic [ADDR_W-1:0]        pos0_reg, pos0_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic                     append_reg, append_next;
    logic [STS_W-1:0]         res_status_reg, res_status_next;
    logic signed [DATA_W-1:0] res_elem_reg, res_elem_next;
    logic [POS_W-1:0]         res_found_reg, res_found_next;
    logic                     out_valid_reg, out_valid_next;
    logic [STS_W-1:0]         out_status_reg, out_status_next;
    logic signed [DATA_W-1:0] out_elem_reg, out_elem_next;
    logic [POS_W-1:0]         out_found_reg, out_found_next;
    logic [POS_W-1:0]         out_count_reg, out_count_next;

    // list storage
    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_wa;
    logic signed [DATA_W-1:0] mem_wd;

    logic [WIDE_W-1:0] pos_w;
    logic [WIDE_W-1:0] used_w;
    logic [ADDR_W-1:0] last_idx;
    logic [ADDR_W-1:0] req_pos0;
    logic [POS_W-1:0]  pidx_found;
    logic              accept;
    logic              out_free;

    assign pos_w      = WIDE_W'(req.position);
    assign used_w     = WIDE_W'(used_reg);
    assign last_idx   = ADDR_W'(used_reg - 1'b1);
    assign req_pos0   = ADDR_W'(req.position - 1'b1);
    assign pidx_found = POS_W'(LEN_W'(pidx_reg) + 1'b1);
    assign accept     = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.element        = out_elem_reg;
    assign rsp.found_position = out_found_reg;
    assign rsp.count          = out_count_reg;

    // memory: registered read from the walk index, one write a cycle
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[idx_reg];
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    // write port selection
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = pos0_reg;
        mem_wd = rd_data_reg;
        case (state_reg)
            S_SHUP, S_SHUPL:
            begin
                mem_we = pend_reg;
                mem_wa = pidx_reg + 1'b1;
            end
            S_SHDN, S_SHDNL:
            begin
                mem_we = pend_reg && (pidx_reg != pos0_reg);
                mem_wa = pidx_reg - 1'b1;
            end
            S_INSW:
            begin
                mem_we = 1'b1;
                mem_wd = value_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // control sequencer
    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        idx_next        = idx_reg;
        pidx_next       = pidx_reg;
        pend_next       = pend_reg;
        pos0_next       = pos0_reg;
        value_next      = value_reg;
        append_next     = append_reg;
        res_status_next = res_status_reg;
        res_elem_next   = res_elem_reg;
        res_found_next  = res_found_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_elem_next   = out_elem_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_next      = req.value;
                    append_next     = (req.action == ACT_APPEND);
                    res_status_next = ST_OK;
                    res_elem_next   = '0;
                    res_found_next  = '0;
                    pend_next       = 1'b0;
                    state_next      = S_DONE;
                    case (req.action)
                        ACT_CLEAR:
                        begin
                            used_next = '0;
                        end
                        ACT_INSERT:
                        begin
                            pos0_next = req_pos0;
                            if (used_reg == LEN_W'(CAPACITY))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (pos_w == '0 || pos_w > used_w + 1'b1)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else if (pos_w <= used_w)
                            begin
                                idx_next   = last_idx;
                                state_next = S_SHUP;
                            end
                            else
                            begin
                                state_next = S_INSW;
                            end
                        end
                        ACT_DELETE, ACT_GET:
                        begin
                            pos0_next = req_pos0;
                            idx_next  = req_pos0;
                            if (used_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else if (pos_w == '0 || pos_w > used_w)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else if (req.action == ACT_DELETE)
                            begin
                                state_next = S_SHDN;
                            end
                            else
                            begin
                                state_next = S_GETR;
                            end
                        end
                        ACT_LOCATE, ACT_APPEND:
                        begin
                            idx_next = '0;
                            if (used_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                            else if (req.action == ACT_APPEND)
                            begin
                                pos0_next  = '0;
                                state_next = S_INSW;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // move entries up, from the tail down to the insert point
            S_SHUP:
            begin
                pend_next = 1'b1;
                pidx_next = idx_reg;
                if (idx_reg == pos0_reg)
                begin
                    state_next = S_SHUPL;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_SHUPL:
            begin
                pend_next  = 1'b0;
                state_next = S_INSW;
            end

            // write the new entry
            S_INSW:
            begin
                used_next      = used_reg + 1'b1;
                res_found_next = '0;
                state_next     = S_DONE;
            end

            // capture the removed entry, then move later entries down
            S_SHDN:
            begin
                if (pend_reg && pidx_reg == pos0_reg)
                begin
                    res_elem_next = rd_data_reg;
                end
                pend_next = 1'b1;
                pidx_next = idx_reg;
                if (idx_reg == last_idx)
                begin
                    state_next = S_SHDNL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SHDNL:
            begin
                if (pidx_reg == pos0_reg)
                begin
                    res_elem_next = rd_data_reg;
                end
                pend_next  = 1'b0;
                used_next  = used_reg - 1'b1;
                state_next = S_DONE;
            end

            // single read
            S_GETR:
            begin
                state_next = S_GETW;
            end
            S_GETW:
            begin
                res_elem_next = rd_data_reg;
                state_next    = S_DONE;
            end

            // linear search from the head
            S_SCAN:
            begin
                if (pend_reg && rd_data_reg == value_reg)
                begin
                    res_found_next = pidx_found;
                    pend_next      = 1'b0;
                    state_next     = S_DONE;
                end
                else
                begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                    if (idx_reg == last_idx)
                    begin
                        state_next = S_SCANL;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_SCANL:
            begin
                pend_next = 1'b0;
                if (rd_data_reg == value_reg)
                begin
                    res_found_next = pidx_found;
                    state_next     = S_DONE;
                end
                else if (!append_reg)
                begin
                    state_next = S_DONE;
                end
                else if (used_reg == LEN_W'(CAPACITY))
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    pos0_next  = ADDR_W'(used_reg);
                    state_next = S_INSW;
                end
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_elem_next   = res_elem_reg;
                    out_found_next  = res_found_reg;
                    out_count_next  = POS_W'(used_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pidx_reg       <= pidx_next;
        pos0_reg       <= pos0_next;
        value_reg      <= value_next;
        append_reg     <= append_next;
        res_status_reg <= res_status_next;
        res_elem_reg   <= res_elem_next;
        res_found_reg  <= res_found_next;
        out_status_reg <= out_status_next;
        out_elem_reg   <= out_elem_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
    end

endmodule

>>> design/pal_checker.sv
`timescale 1ns / 1ps

module pal_checker
    import pal_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic [STS_W-1:0]         rsp_status,
    input logic signed [DATA_W-1:0] rsp_element,
    input logic [POS_W-1:0]         rsp_found_position,
    input logic [POS_W-1:0]         rsp_count
);

    // a stalled response transaction stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // length never exceeds the capacity
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_count <= POS_W'(CAPACITY))
        else $error("count above capacity");

    // an empty report comes with a zero length, a full report with a full list
    a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status != ST_EMPTY || rsp_count == '0) &&
                      (rsp_status != ST_FULL || rsp_count == POS_W'(CAPACITY)))
        else $error("status disagrees with count");

    // a failed request returns no element
    a_elem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_element == '0)
        else $error("element on failed request");

    // a match lies inside the list
    a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_found_position <= rsp_count)
        else $error("found position beyond list");

endmodule

bind positional_array_list_core pal_checker u_pal_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_element        (rsp.element),
    .rsp_found_position (rsp.found_position),
    .rsp_count          (rsp.count)
);

>>> verif/positional_array_list_core_test.sv
`timescale 1ns / 1ps

module positional_array_list_core_test;
    import pal_pkg::*;

    // action codes the block leaves undefined
    localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;

    localparam int STALL_LIMIT     = 4000;
    localparam int ITEMS_PER_PHASE = 620;
    localparam int QUIET_CYCLES    = CAPACITY + 8;

    typedef struct packed {
        logic [STS_W-1:0]         status;
        logic signed [DATA_W-1:0] element;
        logic [POS_W-1:0]         found_position;
        logic [POS_W-1:0]         count;
    } list_rsp_t;

    logic clk;
    logic rst_n;

    pal_req_if req_ch ();
    pal_rsp_if rsp_ch ();

    positional_array_list_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the list
    logic signed [DATA_W-1:0] list_store [CAPACITY];
    int                       list_len;
    list_rsp_t                pending_responses [$];

    int send_idle_pct;
    int recv_idle_pct;
    int n_errors;
    int n_requests;
    int n_checked;
    int peak_len;
    int stall_cycles;
    int status_seen [4];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // first position holding the value, 0 when absent
    function automatic int find_in_list(input logic signed [DATA_W-1:0] val);
        for (int i = 0; i < list_len; i++)
        begin
            if (list_store[i] == val)
                return i + 1;
        end
        return 0;
    endfunction

    // full check first, then position, then shift up
    function automatic logic [STS_W-1:0] insert_entry(input int p,
                                                      input logic signed [DATA_W-1:0] val);
        if (list_len >= CAPACITY)
            return ST_FULL;
        if (p < 1 || p > list_len + 1)
            return ST_RANGE;
        for (int i = list_len; i >= p; i--)
            list_store[i] = list_store[i - 1];
        list_store[p - 1] = val;
        list_len++;
        return ST_OK;
    endfunction

    // expected response for one request, updating the shadow list
    function automatic list_rsp_t predict_list_response(input logic [ACT_W-1:0] act,
                                                        input logic [POS_W-1:0] pos,
                                                        input logic signed [DATA_W-1:0] val);
        list_rsp_t want;
        int        p;
        want = '0;
        p    = pos;
        case (act)
            ACT_CLEAR:
                list_len = 0;
            ACT_INSERT:
                want.status = insert_entry(p, val);
            ACT_DELETE, ACT_GET:
            begin
                if (list_len == 0)
                    want.status = ST_EMPTY;
                else if (p < 1 || p > list_len)
                    want.status = ST_RANGE;
                else
                begin
                    want.element = list_store[p - 1];
                    if (act == ACT_DELETE)
                    begin
                        for (int i = p; i < list_len; i++)
                            list_store[i - 1] = list_store[i];
                        list_len--;
                    end
                end
            end
            ACT_LOCATE:
                want.found_position = POS_W'(find_in_list(val));
            ACT_APPEND:
            begin
                want.found_position = POS_W'(find_in_list(val));
                if (want.found_position == '0)
                    want.status = insert_entry(list_len + 1, val);
            end
            default:
                ;
        endcase
        want.count = POS_W'(list_len);
        if (list_len > peak_len)
            peak_len = list_len;
        return want;
    endfunction

    // value not currently held in the list
    function automatic logic signed [DATA_W-1:0] absent_value();
        logic signed [DATA_W-1:0] v;
        do
            v = $urandom;
        while (find_in_list(v) != 0);
        return v;
    endfunction

    // mostly legal positions for insert, delete and get, some at the boundaries, some anywhere; other actions anywhere
    function automatic logic [POS_W-1:0] pick_position(input logic [ACT_W-1:0] act);
        int top;
        int r;
        if (act != ACT_INSERT && act != ACT_DELETE && act != ACT_GET)
            return POS_W'($urandom_range(0, (1 << POS_W) - 1));
        top = (act == ACT_INSERT) ? list_len + 1 : list_len;
        r   = $urandom_range(99);
        if (r < 86 && top > 0)
            return POS_W'($urandom_range(1, top));
        if (r < 94)
        begin
            case ($urandom_range(2))
                0:       return '0;
                1:       return POS_W'(top + 1);
                default: return POS_W'(top + 2);
            endcase
        end
        return POS_W'($urandom_range(0, (1 << POS_W) - 1));
    endfunction

    // small pool for repeats, extremes, or full random; searches often hit
    function automatic logic signed [DATA_W-1:0] pick_value(input logic [ACT_W-1:0] act);
        if ((act == ACT_LOCATE || act == ACT_APPEND) && list_len > 0 && $urandom_range(1))
            return list_store[$urandom_range(0, list_len - 1)];
        case ($urandom_range(9))
            0, 1, 2, 3: return DATA_W'(int'($urandom_range(0, 8)) - 4);
            4:          return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default:    return $urandom;
        endcase
    endfunction

    // one request transaction, with an optional gap before it
    task automatic send_request(input logic [ACT_W-1:0] act,
                                input logic [POS_W-1:0] pos,
                                input logic signed [DATA_W-1:0] val);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.action   <= ACT_W'($urandom);
            req_ch.position <= POS_W'($urandom);
            req_ch.value    <= $urandom;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.position <= pos;
        req_ch.value    <= val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_responses.push_back(predict_list_response(act, pos, val));
        n_requests++;
    endtask

    // receiver back-pressure and response checking
    always @(posedge clk)
    begin
        list_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_responses.size() == 0)
            begin
                $error("response transaction with no request outstanding");
                n_errors++;
            end
            else
            begin
                want = pending_responses.pop_front();
                n_checked++;
                status_seen[rsp_ch.status]++;
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                    n_errors++;
                end
                if (rsp_ch.element !== want.element)
                begin
                    $error("element: expected %0d, actual %0d", want.element, rsp_ch.element);
                    n_errors++;
                end
                if (rsp_ch.found_position !== want.found_position)
                begin
                    $error("found_position: expected %0d, actual %0d",
                           want.found_position, rsp_ch.found_position);
                    n_errors++;
                end
                if (rsp_ch.count !== want.count)
                begin
                    $error("count: expected %0d, actual %0d", want.count, rsp_ch.count);
                    n_errors++;
                end
            end
        end
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $error("no transaction for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // hand-picked requests covering each action and the error ordering
    task automatic test_directed_cases();
        send_request(ACT_CLEAR, '0, '0);
        send_request(ACT_GET, 7'd1, '0);
        send_request(ACT_DELETE, 7'd0, '0);
        send_request(ACT_INSERT, 7'd0, 32'sd5);
        send_request(ACT_INSERT, 7'd2, 32'sd5);
        send_request(ACT_INSERT, 7'd1, 32'sh7fffffff);
        send_request(ACT_INSERT, 7'd1, 32'sh80000000);
        send_request(ACT_INSERT, 7'd3, 32'sd0);
        send_request(ACT_INSERT, 7'd2, -32'sd1);
        send_request(ACT_GET, 7'd1, '0);
        send_request(ACT_GET, 7'd4, '0);
        send_request(ACT_GET, 7'd5, '0);
        send_request(ACT_GET, 7'd0, '0);
        send_request(ACT_LOCATE, 7'd127, -32'sd1);
        send_request(ACT_LOCATE, 7'd0, 32'sd12345);
        send_request(ACT_APPEND, 7'd0, 32'sd0);
        send_request(ACT_APPEND, 7'd127, 32'sd7);
        send_request(ACT_DELETE, 7'd2, '0);
        send_request(ACT_DELETE, 7'd127, '0);
        send_request(ACT_RSVD6, 7'd127, 32'sh7fffffff);
        send_request(ACT_RSVD7, 7'd1, 32'sh80000000);
        send_request(ACT_INSERT, 7'd127, 32'sd9);
        send_request(ACT_DELETE, 7'd4, '0);
        send_request(ACT_CLEAR, 7'd127, -32'sd1);
        send_request(ACT_LOCATE, 7'd0, 32'sd0);
        send_request(ACT_DELETE, 7'd1, '0);
    endtask

    // fill to capacity, then probe the full list
    task automatic test_capacity_edges();
        logic signed [DATA_W-1:0] v;
        send_request(ACT_CLEAR, '0, '0);
        while (list_len < CAPACITY)
            send_request(ACT_INSERT, POS_W'($urandom_range(1, list_len + 1)), $urandom);
        v = absent_value();
        send_request(ACT_INSERT, 7'd1, v);
        send_request(ACT_INSERT, 7'd0, v);
        send_request(ACT_APPEND, '0, v);
        send_request(ACT_APPEND, '0, list_store[CAPACITY - 1]);
        send_request(ACT_LOCATE, '0, list_store[CAPACITY - 1]);
        send_request(ACT_GET, POS_W'(CAPACITY), '0);
        send_request(ACT_GET, POS_W'(CAPACITY + 1), '0);
        send_request(ACT_DELETE, POS_W'(CAPACITY), '0);
        send_request(ACT_APPEND, '0, v);
        send_request(ACT_DELETE, 7'd1, '0);
    endtask

    // random traffic swinging the list between empty and full
    task automatic test_random_traffic(input int n_items);
        bit                       growing;
        int                       r;
        logic [ACT_W-1:0]         act;
        logic signed [DATA_W-1:0] val;
        logic [POS_W-1:0]         pos;
        growing = 1'b1;
        for (int k = 0; k < n_items; k++)
        begin
            if (list_len >= CAPACITY)
                growing = 1'b0;
            else if (list_len == 0)
                growing = 1'b1;
            else if ($urandom_range(99) < 2)
                growing = !growing;
            r = $urandom_range(99);
            if (r < 1)
                act = ACT_CLEAR;
            else if (r < 3)
                act = $urandom_range(1) ? ACT_RSVD6 : ACT_RSVD7;
            else if (r < 15)
                act = ACT_GET;
            else if (r < 27)
                act = ACT_LOCATE;
            else if (r < 62)
                act = growing ? ACT_INSERT : ACT_DELETE;
            else if (r < 74)
                act = ACT_APPEND;
            else if (r < 86)
                act = growing ? ACT_DELETE : ACT_INSERT;
            else
                act = ACT_GET;
            pos = pick_position(act);
            val = pick_value(act);
            send_request(act, pos, val);
        end
    endtask

    // wait for every response, then a quiet spell to catch strays
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        if (pending_responses.size() != 0)
        begin
            $error("%0d responses never arrived", pending_responses.size());
            n_errors++;
        end
    endtask

    // test sequence
    initial
    begin
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.action   = ACT_CLEAR;
        req_ch.position = '0;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        list_len        = 0;
        n_errors        = 0;
        n_requests      = 0;
        n_checked       = 0;
        peak_len        = 0;
        stall_cycles    = 0;
        for (int i = 0; i < 4; i++)
            status_seen[i] = 0;
        send_idle_pct = 11;
        recv_idle_pct = 73;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_capacity_edges();
        test_random_traffic(ITEMS_PER_PHASE);
        send_idle_pct = 73;
        recv_idle_pct = 11;
        test_random_traffic(ITEMS_PER_PHASE);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(ITEMS_PER_PHASE);
        drain_responses();

        $display("%0d requests sent, %0d responses checked, longest list %0d of %0d",
                 n_requests, n_checked, peak_len, CAPACITY);
        $display("statuses seen: ok %0d, empty %0d, out of range %0d, full %0d",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_RANGE],
                 status_seen[ST_FULL]);
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
